>>> rtl/sroe_pkg.sv
// Package for the shift register output expander: command and result payload
// types, opcode codes, word constants and the shadow reset value.
// No dependencies.
package sroe_pkg;

    localparam int unsigned WordBits = 16;
    localparam int unsigned CntBits  = $clog2(WordBits);

    typedef enum logic [1:0] {
        OP_RAW_WRITE = 2'd0,
        OP_SET_LEDS  = 2'd1,
        OP_SET_ENA   = 2'd2,
        OP_SET_DIR   = 2'd3
    } t_opcode;

    localparam logic [WordBits-1:0] LED_MASK    = 16'hFFC0;
    localparam logic [WordBits-1:0] DIR_MASK    = 16'h0015;
    localparam logic [WordBits-1:0] ENA_MASK    = 16'h002A;
    localparam logic [WordBits-1:0] TOP_BIT     = 16'h8000;
    localparam logic [WordBits-1:0] SHADOW_INIT = ENA_MASK;
    localparam logic [1:0]          NUM_DRIVERS = 2'd3;

    typedef struct packed {
        t_opcode               opcode;
        logic [WordBits-1:0]   raw_word;
        logic [9:0]            led_pattern;
        logic [1:0]            driver_index;
        logic                  bit_value;
    } t_cmd;

    typedef struct packed {
        logic                  serial_bit;
        logic [WordBits-1:0]   output_word;
        logic                  latch_strobe;
    } t_res;

endpackage

>>> rtl/sroe_cmd_if.sv
// Valid/ready channel carrying one command transfer (sroe_pkg::t_cmd).
// Depends on sroe_pkg.
interface sroe_cmd_if;
    logic          valid;
    logic          ready;
    sroe_pkg::t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sroe_res_if.sv
// Valid/ready channel carrying one serial result transfer (sroe_pkg::t_res).
// Depends on sroe_pkg.
interface sroe_res_if;
    logic          valid;
    logic          ready;
    sroe_pkg::t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/sroe_update.sv
// Combinational word update: builds the new output word from the shadow and
// one command. Depends on sroe_pkg.
module sroe_update (
    input  logic [sroe_pkg::WordBits-1:0] i_shadow,
    input  sroe_pkg::t_cmd                i_cmd,
    output logic [sroe_pkg::WordBits-1:0] o_word
);

    logic [sroe_pkg::WordBits-1:0] led_bits;
    logic [3:0]                    pos;
    logic [sroe_pkg::WordBits-1:0] bit_mask;
    logic                          idx_ok;

    assign led_bits = {i_cmd.led_pattern[7:0], i_cmd.led_pattern[9],
                       i_cmd.led_pattern[8], 6'd0};
    assign idx_ok   = (i_cmd.driver_index < sroe_pkg::NUM_DRIVERS);

    always_comb begin
        pos = {1'b0, i_cmd.driver_index, 1'b0};
        if (i_cmd.opcode == sroe_pkg::OP_SET_ENA) begin
            pos = pos | 4'd1;
        end
        bit_mask = sroe_pkg::WordBits'(1) << pos;
    end

    always_comb begin
        o_word = i_shadow;
        unique case (i_cmd.opcode)
            sroe_pkg::OP_RAW_WRITE: begin
                o_word = i_cmd.raw_word;
            end
            sroe_pkg::OP_SET_LEDS: begin
                o_word = (i_shadow & ~sroe_pkg::LED_MASK) | led_bits;
            end
            sroe_pkg::OP_SET_ENA, sroe_pkg::OP_SET_DIR: begin
                // bit_value high drives the line low (enable on / direction flag)
                if (idx_ok) begin
                    o_word = i_cmd.bit_value ? (i_shadow & ~bit_mask)
                                             : (i_shadow | bit_mask);
                end
            end
            default: begin
                o_word = i_shadow;
            end
        endcase
    end

endmodule

>>> rtl/shift_register_output_expander_core.sv
// Top level of the shift register output expander: command register, word
// update, shadow and the 16-bit serial shifter.
// Depends on sroe_pkg, sroe_cmd_if, sroe_res_if and sroe_update.
//
//   channel  | dir | payload                                     | transfer
//   ---------+-----+---------------------------------------------+-------------------
//   i_cmd    | in  | opcode, raw_word, led_pattern, driver_index, | valid & ready
//            |     | bit_value                                   |
//   o_res    | out | serial_bit, output_word, latch_strobe       | valid & ready
//
// Each command yields 16 result transfers, one per cycle while o_res is ready,
// MSB first. A command moves from the command register into the shifter,
// and its first result appears once it is in the shifter.
// The command register accepts the next command while the shifter still
// drains the previous word, so consecutive words leave with no gap.
// Reset (synchronous, active low) empties both stages and sets the shadow to
// 0x002A, all drivers disabled. A stall on o_res holds the current bit.
module shift_register_output_expander_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sroe_cmd_if.sink    i_cmd,
    sroe_res_if.source  o_res
);

    localparam logic [sroe_pkg::CntBits-1:0] LastBit =
        sroe_pkg::CntBits'(sroe_pkg::WordBits - 1);

    // Command register stage
    logic                          r_in_valid;
    sroe_pkg::t_cmd                r_in_cmd;

    // Shadow of the external chain
    logic [sroe_pkg::WordBits-1:0] r_shadow;

    // Shifter stage
    logic                          r_sh_valid;
    logic [sroe_pkg::WordBits-1:0] r_sh_word;
    logic [sroe_pkg::CntBits-1:0]  r_cnt;

    logic [sroe_pkg::WordBits-1:0] n_word;
    logic                          in_xfer;
    logic                          out_xfer;
    logic                          last_bit;
    logic                          load;

    sroe_update u_update (
        .i_shadow (r_shadow),
        .i_cmd    (r_in_cmd),
        .o_word   (n_word)
    );

    assign last_bit = (r_cnt == LastBit);
    assign out_xfer = o_res.valid && o_res.ready;
    // Move the held command into the shifter once the shifter is empty or
    // finishing its last bit this cycle.
    assign load     = r_in_valid && (!r_sh_valid || (out_xfer && last_bit));

    assign i_cmd.ready = !r_in_valid || load;
    assign in_xfer     = i_cmd.valid && i_cmd.ready;

    assign o_res.valid             = r_sh_valid;
    assign o_res.data.serial_bit   = r_sh_word[LastBit - r_cnt];
    assign o_res.data.output_word  = r_sh_word;
    assign o_res.data.latch_strobe = last_bit;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_sh_valid <= 1'b0;
            r_cnt      <= '0;
            r_shadow   <= sroe_pkg::SHADOW_INIT;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (load) begin
                r_in_valid <= 1'b0;
            end

            if (load) begin
                // Commit the new word: shadow and shifter change together.
                r_sh_valid <= 1'b1;
                r_cnt      <= '0;
                r_shadow   <= n_word;
            end else if (out_xfer) begin
                if (last_bit) begin
                    r_sh_valid <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_cmd <= i_cmd.data;
        end
        if (load) begin
            r_sh_word <= n_word;
        end
    end

`ifndef SYNTHESIS
    // The word being shifted out is always the current shadow.
    a_word_is_shadow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sh_valid |-> (r_sh_word == r_shadow))
        else $error("shifter word differs from shadow");

    // The shadow changes only when a command moves into the shifter.
    a_shadow_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !load |=> $stable(r_shadow))
        else $error("shadow changed without a load");

    // After the strobe transfer the shifter is empty or restarts at bit zero.
    a_strobe_ends_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && last_bit) |=> (!r_sh_valid || (r_cnt == '0)))
        else $error("word did not end after latch strobe");
`endif

endmodule
